// ===== hdl/mi3_pkg.sv =====
// Package for the 3x3 fixed-point matrix inverse core: widths, types,
// minor index table and pipeline depths. No dependencies.
`default_nettype none

package mi3_pkg;

  // element format
  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int N_EL      = 9;
  localparam int N_ROW     = 3;
  localparam int THR_W     = 31;

  // full-width intermediate widths
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ADJ_W  = PROD_W + 1;
  localparam int MAG_W  = PROD_W;
  localparam int HALF_W = MAG_W / 2;
  localparam int TERM_W = ELEM_W + MAG_W;
  localparam int DET_W  = TERM_W + 2;
  localparam int DMAG_W = DET_W - 1;

  // divider widths: quotient bits QB-1..0 plus one overflow bit
  localparam int QB      = ELEM_W + 1;
  localparam int QW      = QB + 1;
  localparam int NUM_SH  = 2 * FRAC_BITS + 1;
  localparam int DEN_W   = DMAG_W + 1;
  localparam int NUM_W   = ((MAG_W + NUM_SH > DMAG_W) ? MAG_W + NUM_SH : DMAG_W) + 1;
  localparam int REM_W   = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;

  // pipeline depths
  localparam int FRONT_ST = 6;
  localparam int LANE_ST  = QB + 3;
  localparam int PIPE_ST  = FRONT_ST + LANE_ST;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ADJ_W-1:0]  adj_t;
  typedef logic        [MAG_W-1:0]  mag_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic        [DMAG_W-1:0] dmag_t;
  typedef logic        [THR_W-1:0]  thr_t;

  localparam thr_t THR_RESET = thr_t'(7);

  // saturation limits on the unsigned quotient
  localparam logic [QW-1:0] Q_NEG_LIM = QW'(1) << (ELEM_W - 1);
  localparam logic [QW-1:0] Q_POS_LIM = Q_NEG_LIM - QW'(1);

  localparam logic [ELEM_W-1:0] ELEM_MIN = ELEM_W'(1) << (ELEM_W - 1);
  localparam logic [ELEM_W-1:0] ELEM_MAX = ELEM_MIN - ELEM_W'(1);
  localparam elem_t             ONE_Q    = elem_t'(ELEM_W'(1) << FRAC_BITS);

  // adjugate entry k = elem[a]*elem[b] - elem[c]*elem[d]
  localparam int MINOR_IDX [N_EL][4] = '{
    '{4, 8, 5, 7},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{2, 3, 0, 5},
    '{3, 7, 4, 6},
    '{1, 6, 0, 7},
    '{0, 4, 1, 3}
  };

  // determinant info handed from the front end to the lanes
  typedef struct packed {
    logic  sing;
    dmag_t dmag;
  } det_info_t;

  // one merged result transaction
  typedef struct packed {
    elem_t [N_EL-1:0] inv;
    logic             singular;
    logic             saturated;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/mi3_if.sv =====
// Valid/ready channel interfaces for the matrix inverse core.
// Depends on mi3_pkg for the element type.
`default_nettype none

interface mi3_in_if;
  import mi3_pkg::*;
  logic  valid;
  logic  ready;
  elem_t elem0, elem1, elem2, elem3, elem4, elem5, elem6, elem7, elem8;
  modport source (output valid, elem0, elem1, elem2, elem3, elem4, elem5, elem6,
                  elem7, elem8, input ready);
  modport sink (input valid, elem0, elem1, elem2, elem3, elem4, elem5, elem6,
                elem7, elem8, output ready);
endinterface

interface mi3_out_if;
  import mi3_pkg::*;
  logic  valid;
  logic  ready;
  elem_t inv0, inv1, inv2, inv3, inv4, inv5, inv6, inv7, inv8;
  logic  singular;
  logic  saturated;
  modport source (output valid, inv0, inv1, inv2, inv3, inv4, inv5, inv6, inv7,
                  inv8, singular, saturated, input ready);
  modport sink (input valid, inv0, inv1, inv2, inv3, inv4, inv5, inv6, inv7,
                inv8, singular, saturated, output ready);
endinterface

`default_nettype wire

// ===== hdl/mi3_front.sv =====
// Front end: 2x2 minors, adjugate, determinant and singular test (6 stages).
// Depends on mi3_pkg.
`default_nettype none

module mi3_front (
  input  logic              clk,
  input  logic              en,
  input  mi3_pkg::thr_t     thr,
  input  mi3_pkg::elem_t    elem [mi3_pkg::N_EL],
  output mi3_pkg::det_info_t info,
  output mi3_pkg::mag_t     mag [mi3_pkg::N_EL],
  output logic              neg [mi3_pkg::N_EL]
);
  import mi3_pkg::*;

  prod_t prod_a_r [N_EL];
  prod_t prod_b_r [N_EL];
  elem_t row0_r [N_ROW];
  elem_t row1_r [N_ROW];
  adj_t  adj1_r [N_EL];
  adj_t  adj2_r [N_EL];
  adj_t  adj3_r [N_EL];
  adj_t  adj4_r [N_EL];
  logic [ELEM_W-1:0] ea_c [N_ROW];
  mag_t  am_c [N_ROW];
  logic [PROD_W-1:0] pplo_r [N_ROW];
  logic [PROD_W-1:0] pphi_r [N_ROW];
  logic  tneg_r [N_ROW];
  det_t  term_r [N_ROW];
  det_t  det_r;
  dmag_t dmag_c;
  dmag_t thr_sh;
  det_info_t info_r;
  mag_t  mag_r [N_EL];
  logic  neg_r [N_EL];

  genvar k, t;

  // stage 0/1: minor products, then adjugate differences
  for (k = 0; k < N_EL; k++) begin : g_minor
    always_ff @(posedge clk) begin
      if (en) begin
        prod_a_r[k] <= prod_t'(elem[MINOR_IDX[k][0]]) * prod_t'(elem[MINOR_IDX[k][1]]);
        prod_b_r[k] <= prod_t'(elem[MINOR_IDX[k][2]]) * prod_t'(elem[MINOR_IDX[k][3]]);
        adj1_r[k]   <= adj_t'(prod_a_r[k]) - adj_t'(prod_b_r[k]);
        adj2_r[k]   <= adj1_r[k];
        adj3_r[k]   <= adj2_r[k];
        adj4_r[k]   <= adj3_r[k];
      end
    end
  end

  // stage 2/3: first-row element times minor, as two 32x32 partial products
  for (t = 0; t < N_ROW; t++) begin : g_term
    always_comb begin
      ea_c[t] = row1_r[t][ELEM_W-1] ? ELEM_W'(-row1_r[t]) : ELEM_W'(row1_r[t]);
      am_c[t] = adj1_r[3*t][ADJ_W-1] ? MAG_W'(-adj1_r[3*t]) : MAG_W'(adj1_r[3*t]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        row0_r[t] <= elem[t];
        row1_r[t] <= row0_r[t];
        pplo_r[t] <= PROD_W'(ea_c[t]) * PROD_W'(am_c[t][HALF_W-1:0]);
        pphi_r[t] <= PROD_W'(ea_c[t]) * PROD_W'(am_c[t][MAG_W-1:HALF_W]);
        tneg_r[t] <= row1_r[t][ELEM_W-1] ^ adj1_r[3*t][ADJ_W-1];
        term_r[t] <= tneg_r[t]
          ? -$signed(DET_W'({pphi_r[t], {HALF_W{1'b0}}}) + DET_W'(pplo_r[t]))
          :  $signed(DET_W'({pphi_r[t], {HALF_W{1'b0}}}) + DET_W'(pplo_r[t]));
      end
    end
  end

  // stage 4: determinant sum
  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= term_r[0] + term_r[1] + term_r[2];
    end
  end

  // stage 5: magnitude, singular test, per-entry sign and magnitude
  always_comb begin
    dmag_c = det_r[DET_W-1] ? DMAG_W'(-det_r) : DMAG_W'(det_r);
    thr_sh = DMAG_W'({thr, {(2*FRAC_BITS){1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      info_r.dmag <= dmag_c;
      info_r.sing <= (dmag_c == '0) || (dmag_c < thr_sh);
    end
  end

  for (k = 0; k < N_EL; k++) begin : g_out
    always_ff @(posedge clk) begin
      if (en) begin
        mag_r[k] <= adj4_r[k][ADJ_W-1] ? MAG_W'(-adj4_r[k]) : MAG_W'(adj4_r[k]);
        neg_r[k] <= adj4_r[k][ADJ_W-1] ^ det_r[DET_W-1];
      end
    end
    assign mag[k] = mag_r[k];
    assign neg[k] = neg_r[k];
  end

  assign info = info_r;

endmodule

`default_nettype wire

// ===== hdl/mi3_lane.sv =====
// One divide lane: rounded adj / det by pipelined restoring division,
// one quotient bit per stage, then sign and saturation. Depends on mi3_pkg.
`default_nettype none

module mi3_lane (
  input  logic           clk,
  input  logic           en,
  input  mi3_pkg::mag_t  mag,
  input  logic           neg,
  input  mi3_pkg::dmag_t dmag,
  output mi3_pkg::elem_t inv,
  output logic           sat
);
  import mi3_pkg::*;

  logic [REM_W-1:0] rem_r [QB+2];
  logic [DEN_W-1:0] den_r [QB+2];
  logic [QW-1:0]    q_r   [QB+2];
  logic             neg_r [QB+2];
  logic [QW-1:0]    qf;
  logic [ELEM_W-1:0] res_c;
  logic             ovf_c;
  logic [ELEM_W-1:0] inv_r;
  logic             sat_r;

  genvar s;

  // numerator with the rounding half-divisor added, divisor doubled
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= (REM_W'(mag) << NUM_SH) + REM_W'(dmag);
      den_r[0] <= {dmag, 1'b0};
      q_r[0]   <= '0;
      neg_r[0] <= neg;
    end
  end

  // one quotient bit per stage, overflow bit first
  for (s = 1; s <= QB + 1; s++) begin : g_step
    localparam int J = QB + 1 - s;
    logic [REM_W-1:0] dsh;
    logic             ge;
    logic [QW-1:0]    q_nxt;

    always_comb begin
      dsh      = REM_W'(den_r[s-1]) << J;
      ge       = rem_r[s-1] >= dsh;
      q_nxt    = q_r[s-1];
      q_nxt[J] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? rem_r[s-1] - dsh : rem_r[s-1];
        den_r[s] <= den_r[s-1];
        q_r[s]   <= q_nxt;
        neg_r[s] <= neg_r[s-1];
      end
    end
  end

  // sign and clamp to the element range
  always_comb begin
    qf = q_r[QB+1];
    if (neg_r[QB+1]) begin
      ovf_c = qf > Q_NEG_LIM;
      res_c = ovf_c ? ELEM_MIN : (~qf[ELEM_W-1:0]) + ELEM_W'(1);
    end else begin
      ovf_c = qf > Q_POS_LIM;
      res_c = ovf_c ? ELEM_MAX : qf[ELEM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv_r <= res_c;
      sat_r <= ovf_c;
    end
  end

  assign inv = elem_t'(inv_r);
  assign sat = sat_r;

endmodule

`default_nettype wire

// ===== hdl/matrix_inverse_3x3_core.sv =====
// Input transaction to result: 6 front-end stages, 36 divide stages, 1 output
// register; one lane per inverse element. Throughput: one matrix per cycle
// while the skid entry is empty; an output register plus one skid entry keeps
// input ready while one result waits. Reset (rst_n, synchronous) empties the
// pipeline and sets the singular threshold to 7.
// Depends on mi3_pkg, mi3_if, mi3_front and mi3_lane.
`default_nettype none

module matrix_inverse_3x3_core (
  input  logic          clk,
  input  logic          rst_n,
  mi3_in_if.sink        in_chan,
  mi3_out_if.source     out_chan,
  input  logic          cfg_we,
  input  mi3_pkg::thr_t cfg_wdata
);
  import mi3_pkg::*;

  thr_t      thr_r;
  logic      en;
  logic [PIPE_ST-1:0] vld_r;
  logic [LANE_ST-1:0] sing_r;
  elem_t     elem [N_EL];
  det_info_t info;
  mag_t      mag [N_EL];
  logic      neg [N_EL];
  elem_t     lane_inv [N_EL];
  logic [N_EL-1:0] lane_sat;
  logic      incoming;
  result_t   mrg;
  logic      out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  result_t   out_d_r, out_d_nxt, skid_d_r, skid_d_nxt;

  genvar k;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // pipeline moves while the skid register is free
  assign en            = !skid_v_r;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_ST-2:0], in_chan.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing_r <= {sing_r[LANE_ST-2:0], info.sing};
    end
  end

  assign elem[0] = in_chan.elem0;
  assign elem[1] = in_chan.elem1;
  assign elem[2] = in_chan.elem2;
  assign elem[3] = in_chan.elem3;
  assign elem[4] = in_chan.elem4;
  assign elem[5] = in_chan.elem5;
  assign elem[6] = in_chan.elem6;
  assign elem[7] = in_chan.elem7;
  assign elem[8] = in_chan.elem8;

  mi3_front u_front (
    .clk  (clk),
    .en   (en),
    .thr  (thr_r),
    .elem (elem),
    .info (info),
    .mag  (mag),
    .neg  (neg)
  );

  // divide lanes
  for (k = 0; k < N_EL; k++) begin : g_lane
    mi3_lane u_lane (
      .clk  (clk),
      .en   (en),
      .mag  (mag[k]),
      .neg  (neg[k]),
      .dmag (info.dmag),
      .inv  (lane_inv[k]),
      .sat  (lane_sat[k])
    );
  end

  // merge lane results, identity for a degenerate matrix
  always_comb begin
    mrg.singular  = sing_r[LANE_ST-1];
    mrg.saturated = !sing_r[LANE_ST-1] && (|lane_sat);
    for (int i = 0; i < N_EL; i++) begin
      if (sing_r[LANE_ST-1]) begin
        mrg.inv[i] = (i % 4 == 0) ? ONE_Q : elem_t'(0);
      end else begin
        mrg.inv[i] = lane_inv[i];
      end
    end
  end

  assign incoming = vld_r[PIPE_ST-1] && en;

  // output register with skid entry
  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    skid_d_nxt = skid_d_r;
    if (out_v_r && out_chan.ready) begin
      if (skid_v_r) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else if (incoming) begin
        out_d_nxt = mrg;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (incoming) begin
      if (!out_v_r) begin
        out_d_nxt = mrg;
        out_v_nxt = 1'b1;
      end else begin
        skid_d_nxt = mrg;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_chan.valid     = out_v_r;
  assign out_chan.inv0      = out_d_r.inv[0];
  assign out_chan.inv1      = out_d_r.inv[1];
  assign out_chan.inv2      = out_d_r.inv[2];
  assign out_chan.inv3      = out_d_r.inv[3];
  assign out_chan.inv4      = out_d_r.inv[4];
  assign out_chan.inv5      = out_d_r.inv[5];
  assign out_chan.inv6      = out_d_r.inv[6];
  assign out_chan.inv7      = out_d_r.inv[7];
  assign out_chan.inv8      = out_d_r.inv[8];
  assign out_chan.singular  = out_d_r.singular;
  assign out_chan.saturated = out_d_r.saturated;

`ifndef SYNTH
  // skid entry only fills behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid full with output empty");

  // a degenerate matrix never reports saturation
  a_sing_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_d_r.singular) |-> !out_d_r.saturated)
    else $error("singular result flagged saturated");

  // a stalled pipeline holds its valid bits
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && $past(rst_n)) |=> $stable(vld_r)) else $error("pipeline moved while stalled");

  // an accepted transaction enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> vld_r[0]) else $error("accepted transaction lost");
`endif

endmodule

`default_nettype wire
